FILE: rtl/supply_fault_qualifier_top_macros.svh
// assertion macros shared by the supply fault qualifier rtl
`ifndef SUPPLY_FAULT_QUALIFIER_TOP_MACROS_SVH
`define SUPPLY_FAULT_QUALIFIER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sfq_pkg.sv
// shared types and constants of the supply fault qualifier
`default_nettype none
package sfq_pkg;

    // window and line geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int LINE_COUNT   = 6;
    localparam int CHAN_COUNT   = 3;
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = $clog2(LINE_COUNT);

    // field widths
    localparam int THR_W     = 7;
    localparam int PERSIST_W = 16;
    localparam int TIME_W    = 32;
    localparam int CH_W      = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [THR_W-1:0]     THRESH_RST  = 7'd4;
    localparam logic [PERSIST_W-1:0] PERSIST_RST = 16'd100;

    // register index codes
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_PERSIST   = 2'd1,
        REG_RESTORE   = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_EVALUATE = 2'd1,
        KIND_RESET    = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_SWEEP,
        ST_THRESH,
        ST_EVAL,
        ST_RESP
    } state_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic ram_wr_en;
        logic accumulate;
        logic threshold;
        logic eval_step;
        logic respond;
    } seq_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/sfq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/supply_fault_qualifier_top.sv
// top level of the supply fault qualifier: sequencer, window counter and fault timers
// steps: a sample word takes sample and response, plus sweep and threshold if it fills
// the window; an evaluate word steps every line; other kinds go straight to response
// throughput: one word at a time; the window count walks the sample ram one entry a cycle
// and the timers share one 32-bit subtract-compare, one line a cycle
// reset: rst_n clears state, timers and flags and loads register reset values at once; no clearing pass
`default_nettype none
module supply_fault_qualifier_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // power_good[2:0], over_current[5:3], channel_active[8:6], now_ms[40:9],
    // channel[42:41], zero fill[47:43]
    input  wire logic [sfq_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  wire logic [1:0]                      s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // filtered_faults[5:0], timed_faults[11:6], any_fault[12], sticky_fault[13],
    // restart_req[16:14], disable_request[19:17], zero fill[23:20]
    output logic      [sfq_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfq_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sfq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [sfq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    import sfq_pkg::*;

    `include "supply_fault_qualifier_top_macros.svh"

    // configuration registers
    logic [THR_W-1:0]     thresh_reg;
    logic [PERSIST_W-1:0] persist_reg;
    logic                 restore_reg;

    // sequencer
    state_t    state_reg, state_next;
    seq_ctrl_t ctrl;

    // captured word
    kind_t                 kind_reg;
    logic [LINE_COUNT-1:0] word_reg;
    logic [TIME_W-1:0]     now_reg;

    // window state
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      sweep_reg, sweep_next;
    logic [CNT_W-1:0]      cnt_reg  [LINE_COUNT];
    logic [CNT_W-1:0]      cnt_next [LINE_COUNT];
    logic [LINE_COUNT-1:0] filtered_reg, filtered_next;
    logic [LINE_COUNT-1:0] ram_rd_data;
    logic                  pos_wrap;
    logic                  sweep_last;

    // timer state
    logic [TIME_W-1:0]     start_reg  [LINE_COUNT];
    logic [TIME_W-1:0]     start_next [LINE_COUNT];
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [LINE_COUNT-1:0] timed_reg, timed_next;
    logic                  sticky_reg, sticky_next;
    logic [TIME_W-1:0]     elapsed;
    logic                  eval_last;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  out_free;

    // input fields
    logic [CHAN_COUNT-1:0] in_pg;
    logic [CHAN_COUNT-1:0] in_oc;
    logic [CHAN_COUNT-1:0] in_act;
    logic [TIME_W-1:0]     in_now;
    logic [CH_W-1:0]       in_chan;
    logic                  in_accept;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;

    assign in_pg     = s_tdata[2:0];
    assign in_oc     = s_tdata[5:3];
    assign in_act    = s_tdata[8:6];
    assign in_now    = s_tdata[40:9];
    assign in_chan   = s_tdata[42:41];
    assign in_accept = s_tvalid && s_tready;

    assign pos_wrap   = (pos_reg == POS_W'(WINDOW_DEPTH - 1));
    assign sweep_last = (sweep_reg == POS_W'(WINDOW_DEPTH - 1));
    assign eval_last  = (idx_reg == IDX_W'(LINE_COUNT - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // register read mux
    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(thresh_reg);
            REG_PERSIST:   prdata = APB_DATA_W'(persist_reg);
            REG_RESTORE:   prdata = APB_DATA_W'(restore_reg);
            default:       prdata = '0;
        endcase
    end

    // sample window storage
    sfq_ram #(
        .WIDTH (LINE_COUNT),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (ctrl.ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (word_reg),
        .rd_addr (sweep_reg),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (kind_t'(s_tuser))
                        KIND_SAMPLE:   state_next = ST_SAMPLE;
                        KIND_EVALUATE: state_next = ST_EVAL;
                        default:       state_next = ST_RESP;
                    endcase
                end
            end
            ST_SAMPLE: state_next = pos_wrap ? ST_SWEEP : ST_RESP;
            ST_SWEEP:  state_next = sweep_last ? ST_THRESH : ST_SWEEP;
            ST_THRESH: state_next = ST_RESP;
            ST_EVAL:   state_next = eval_last ? ST_RESP : ST_EVAL;
            ST_RESP:   state_next = out_free ? ST_IDLE : ST_RESP;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:   ctrl.in_ready   = 1'b1;
            ST_SAMPLE: ctrl.ram_wr_en  = 1'b1;
            ST_SWEEP:  ctrl.accumulate = 1'b1;
            ST_THRESH: ctrl.threshold  = 1'b1;
            ST_EVAL:   ctrl.eval_step  = 1'b1;
            ST_RESP:   ctrl.respond    = out_free;
            default:   ctrl = '0;
        endcase
    end

    assign s_tready = ctrl.in_ready;

    // window position, sweep counter, per-line counts and filtered flags
    always_comb
    begin
        pos_next      = pos_reg;
        sweep_next    = sweep_reg;
        filtered_next = filtered_reg;
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (ctrl.ram_wr_en)
        begin
            pos_next   = pos_wrap ? '0 : pos_reg + POS_W'(1);
            sweep_next = '0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                cnt_next[i] = '0;
            end
        end
        if (ctrl.accumulate)
        begin
            sweep_next = sweep_reg + POS_W'(1);
            // read data belongs to the address of the previous cycle
            if (sweep_reg != '0)
            begin
                for (int i = 0; i < LINE_COUNT; i++)
                begin
                    cnt_next[i] = cnt_reg[i] + CNT_W'(ram_rd_data[i]);
                end
            end
        end
        // last entry arrives here; count it and compare
        if (ctrl.threshold)
        begin
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                filtered_next[i] =
                    THR_W'(cnt_reg[i] + CNT_W'(ram_rd_data[i])) >= thresh_reg;
            end
        end
    end

    // shared elapsed-time subtractor
    assign elapsed = now_reg - start_reg[idx_reg];

    // fault timers, one line per cycle
    always_comb
    begin
        idx_next    = idx_reg;
        timed_next  = timed_reg;
        sticky_next = sticky_reg;
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            start_next[i] = start_reg[i];
        end
        if (in_accept)
        begin
            idx_next = '0;
            // channel timer restart
            if (kind_t'(s_tuser) == KIND_RESET && in_chan < CH_W'(CHAN_COUNT))
            begin
                start_next[in_chan]                            = in_now;
                start_next[IDX_W'(in_chan) + IDX_W'(CHAN_COUNT)] = in_now;
            end
        end
        if (ctrl.eval_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (filtered_reg[idx_reg])
            begin
                if (elapsed > TIME_W'(persist_reg))
                begin
                    timed_next[idx_reg] = 1'b1;
                end
            end
            else
            begin
                start_next[idx_reg] = now_reg;
                timed_next[idx_reg] = 1'b0;
            end
        end
        if (ctrl.respond && kind_reg == KIND_EVALUATE)
        begin
            sticky_next = sticky_reg || (timed_reg != '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            thresh_reg   <= THRESH_RST;
            persist_reg  <= PERSIST_RST;
            restore_reg  <= 1'b0;
            pos_reg      <= '0;
            filtered_reg <= '0;
            timed_reg    <= '0;
            sticky_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            filtered_reg <= filtered_next;
            timed_reg    <= timed_next;
            sticky_reg   <= sticky_next;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                start_reg[i] <= start_next[i];
            end
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    REG_THRESHOLD: thresh_reg  <= pwdata[THR_W-1:0];
                    REG_PERSIST:   persist_reg <= pwdata[PERSIST_W-1:0];
                    REG_RESTORE:   restore_reg <= pwdata[0];
                    default:       ;
                endcase
            end
            if (ctrl.respond)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        idx_reg   <= idx_next;
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            cnt_reg[i] <= cnt_next[i];
        end
        if (in_accept)
        begin
            kind_reg <= kind_t'(s_tuser);
            now_reg  <= in_now;
            word_reg <= {in_oc & in_act, ~in_pg & in_act};
        end
        if (ctrl.respond)
        begin
            m_tdata_reg <= {
                4'b0000,
                (kind_reg == KIND_EVALUATE && !restore_reg) ? timed_reg[2:0] : 3'b000,
                (kind_reg == KIND_EVALUATE &&  restore_reg) ? timed_reg[2:0] : 3'b000,
                sticky_next,
                timed_reg != '0,
                timed_reg,
                filtered_reg
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `SFQ_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready,
        "input accepted twice without processing")
    `SFQ_ASSERT_NOW(a_result_from_resp, $rose(m_tvalid_reg), $past(state_reg) == ST_RESP,
        "result raised outside the response step")
    `SFQ_ASSERT_NOW(a_sticky_holds, 1'b1, !$fell(sticky_reg),
        "sticky fault flag cleared")
    `SFQ_ASSERT_NOW(a_eval_index, state_reg == ST_EVAL, idx_reg < IDX_W'(LINE_COUNT),
        "timer step index past last line")
    `SFQ_ASSERT_NEXT(a_sample_no_overwrite, m_tvalid_reg && !m_tready,
        m_tvalid_reg && $stable(m_tdata_reg),
        "pending result overwritten")

endmodule
`default_nettype wire

FILE: verif/sfq_status_checker.sv
// status checker for the supply fault qualifier: tracks state and checks every status word
module sfq_status_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sfq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sfq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [sfq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfq_pkg::APB_DATA_W-1:0] pwdata,
    output int                             mismatch_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfq_pkg::*;

    typedef struct packed {
        logic [LINE_COUNT-1:0] filtered;
        logic [LINE_COUNT-1:0] timed;
        logic                  any_fault;
        logic                  sticky;
        logic [2:0]            restart_req;
        logic [2:0]            disable_req;
    } fault_status_t;

    // tracked qualifier state
    logic [LINE_COUNT-1:0] window_lines [WINDOW_DEPTH];
    int unsigned           window_fill;
    logic [LINE_COUNT-1:0] filtered_lines;
    logic [LINE_COUNT-1:0] timed_lines;
    logic [TIME_W-1:0]     onset_ms [LINE_COUNT];
    logic                  sticky_seen;

    // register copies
    logic [THR_W-1:0]      threshold;
    logic [PERSIST_W-1:0]  persist_ms;
    logic                  restore;

    fault_status_t         expected_status [$];

    // advance the tracked state by one input word and form its status word
    task automatic qualify_word(input kind_t kind, input logic [IN_DATA_W-1:0] data,
                                output fault_status_t status);
        logic [2:0]        pg;
        logic [2:0]        oc;
        logic [2:0]        act;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] elapsed;
        logic [CH_W-1:0]   chan;
        int                ones;
        pg   = data[2:0];
        oc   = data[5:3];
        act  = data[8:6];
        now  = data[40:9];
        chan = data[42:41];
        status = '0;
        case (kind)
            KIND_SAMPLE:
            begin
                // inactive channels sample as fault-free
                window_lines[window_fill] = {oc & act, ~pg & act};
                if (window_fill == WINDOW_DEPTH - 1)
                begin
                    window_fill = 0;
                    // full window: count each line over every entry
                    for (int b = 0; b < LINE_COUNT; b++)
                    begin
                        ones = 0;
                        for (int i = 0; i < WINDOW_DEPTH; i++)
                            ones += window_lines[i][b];
                        filtered_lines[b] = (ones >= int'(threshold));
                    end
                end
                else
                    window_fill++;
            end
            KIND_EVALUATE:
            begin
                // persistence timing with wrapping millisecond ticks
                for (int i = 0; i < LINE_COUNT; i++)
                begin
                    if (filtered_lines[i])
                    begin
                        elapsed = now - onset_ms[i];
                        if (elapsed > TIME_W'(persist_ms))
                            timed_lines[i] = 1'b1;
                    end
                    else
                    begin
                        onset_ms[i]    = now;
                        timed_lines[i] = 1'b0;
                    end
                end
                if (|timed_lines)
                    sticky_seen = 1'b1;
                // only power faults ask for a restart or a disable
                if (restore)
                    status.restart_req = timed_lines[CHAN_COUNT-1:0];
                else
                    status.disable_req = timed_lines[CHAN_COUNT-1:0];
            end
            KIND_RESET:
            begin
                // channel out of range is ignored
                if (chan < CHAN_COUNT)
                begin
                    onset_ms[chan]              = now;
                    onset_ms[chan + CHAN_COUNT] = now;
                end
            end
            default:
            begin
            end
        endcase
        status.filtered  = filtered_lines;
        status.timed     = timed_lines;
        status.any_fault = |timed_lines;
        status.sticky    = sticky_seen;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // register writes, status compare, then prediction of newly accepted words
    always @(posedge clk or negedge rst_n)
    begin : track
        fault_status_t want;
        fault_status_t made;
        if (!rst_n)
        begin
            threshold      = THRESH_RST;
            persist_ms     = PERSIST_RST;
            restore        = 1'b0;
            window_fill    = 0;
            filtered_lines = '0;
            timed_lines    = '0;
            sticky_seen    = 1'b0;
            for (int i = 0; i < LINE_COUNT; i++)
                onset_ms[i] = '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                window_lines[i] = '0;
            expected_status.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_THRESHOLD: threshold  = pwdata[THR_W-1:0];
                    REG_PERSIST:   persist_ms = pwdata[PERSIST_W-1:0];
                    REG_RESTORE:   restore    = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status word 0x%0h arrived with no word outstanding", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("filtered_faults", 32'(want.filtered), 32'(m_tdata[5:0]));
                    check_field("timed_faults", 32'(want.timed), 32'(m_tdata[11:6]));
                    check_field("any_fault", 32'(want.any_fault), 32'(m_tdata[12]));
                    check_field("sticky_fault", 32'(want.sticky), 32'(m_tdata[13]));
                    check_field("restart_req", 32'(want.restart_req), 32'(m_tdata[16:14]));
                    check_field("disable_request", 32'(want.disable_req), 32'(m_tdata[19:17]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                qualify_word(kind_t'(s_tuser), s_tdata, made);
                expected_status.push_back(made);
            end
        end
        pending = expected_status.size();
    end

endmodule

FILE: verif/tb_supply_fault_qualifier_top.sv
// testbench top for the supply fault qualifier: clock, reset, stimulus, ready pattern and verdict
module tb_supply_fault_qualifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfq_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int PHASES          = 8;
    localparam int STALL_LIMIT     = 2000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatch_count;
    int                    pending;
    int                    stall_cycles;

    // idling modes, switched in stretches by the stimulus
    logic                  tx_gaps_on   = 1'b1;
    logic                  rx_stalls_on = 1'b1;
    int                    fault_levels [5] = '{0, 20, 50, 85, 100};

    always #CLK_HALF clk = ~clk;

    supply_fault_qualifier_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sfq_status_checker status_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [2:0] fault_lines(input int pct);
        logic [2:0] f;
        for (int c = 0; c < CHAN_COUNT; c++)
            f[c] = ($urandom_range(0, 99) < pct);
        return f;
    endfunction

    // millisecond advance: mostly small, sometimes beyond the longest persistence
    function automatic logic [31:0] tick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 40);
        if (r < 97)
            return $urandom_range(41, 2000);
        return $urandom_range(30000, 70000);
    endfunction

    // one word on the input stream; returns at the edge that accepts it
    task automatic send_word(input kind_t kind, input logic [2:0] pg, input logic [2:0] oc,
                             input logic [2:0] act, input logic [31:0] now,
                             input logic [1:0] chan);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 1) == 1) ? gap_cycles() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, chan, now, act, oc, pg};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the input stream until every outstanding status word is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // setup and access cycle; the bus stays selected for a following write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic write_config(input logic [6:0] thr, input logic [15:0] persist,
                                input logic restore);
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_PERSIST, 32'(persist));
        write_reg(REG_RESTORE, 32'(restore));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver: runs of ready with random stalls between them
    initial
    begin : ready_pattern
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
                hold_left--;
            else if (rx_stalls_on && m_tready && $urandom_range(0, 2) == 0)
            begin
                m_tready  <= 1'b0;
                hold_left = gap_cycles();
            end
            else
            begin
                m_tready  <= 1'b1;
                hold_left = $urandom_range(1, 12);
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_supply_fault_qualifier_top: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] tick;
        logic [2:0]  pf;
        logic [2:0]  of;
        logic [2:0]  act;
        logic [6:0]  thr;
        logic [15:0] persist;
        logic        restore;
        int          fault_pct;
        int          r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset register values
        send_word(KIND_UNUSED, 3'b101, 3'b010, 3'b111, 32'h1234_5678, 2'd1);
        send_word(KIND_RESET, 3'b000, 3'b111, 3'b111, 32'hFFFF_FFFF, 2'd3);
        send_word(KIND_EVALUATE, 3'b111, 3'b000, 3'b111, 32'd0, 2'd0);
        // one window: four faulty samples, then clean ones, one with a partial active mask
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (i < 4)
                send_word(KIND_SAMPLE, 3'b000, 3'b111, 3'b111, 32'd0, 2'd0);
            else
                send_word(KIND_SAMPLE, 3'b111, 3'b000, (i == 7) ? 3'b010 : 3'b111, 32'd0, 2'd0);
        end
        // exactly at the limit, one past it, a channel restart, a wrapped tick
        send_word(KIND_EVALUATE, 3'b000, 3'b000, 3'b000, 32'd100, 2'd0);
        send_word(KIND_EVALUATE, 3'b000, 3'b000, 3'b000, 32'd101, 2'd0);
        send_word(KIND_RESET, 3'b000, 3'b000, 3'b000, 32'd101, 2'd2);
        send_word(KIND_EVALUATE, 3'b000, 3'b000, 3'b000, 32'hFFFF_FFFF, 2'd0);
        send_word(KIND_SAMPLE, 3'b000, 3'b111, 3'b000, 32'd0, 2'd0);

        // directed: zero threshold and zero persistence with auto restore
        wait_drained();
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        write_config(7'd0, 16'd0, 1'b1);
        for (int i = 0; i < WINDOW_DEPTH; i++)
            send_word(KIND_SAMPLE, 3'b111, 3'b000, 3'b111, 32'd0, 2'd0);
        send_word(KIND_EVALUATE, 3'b000, 3'b000, 3'b111, 32'd3, 2'd0);

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin thr = 7'd3;  persist = 16'd20;   restore = 1'b1; end
                1: begin thr = 7'd0;  persist = 16'd0;    restore = 1'b0; end
                2: begin thr = 7'd64; persist = 16'hFFFF; restore = 1'b1; end
                3: begin thr = 7'd8;  persist = 16'hFFFF; restore = 1'b0; end
                4: begin thr = 7'd9;  persist = 16'd1;    restore = 1'b1; end
                default:
                begin
                    thr     = 7'($urandom_range(1, 8));
                    persist = 16'($urandom_range(0, 400));
                    restore = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drained();
            write_config(thr, persist, restore);
            tick = (phase % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // new fault density and idling mode every stretch
                if (n % 25 == 0)
                begin
                    fault_pct    = fault_levels[$urandom_range(0, 4)];
                    tx_gaps_on   = ($urandom_range(0, 9) < 7);
                    rx_stalls_on = ($urandom_range(0, 9) < 7);
                end
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                tick += tick_step();
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_word(kind_t'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                              3'($urandom), $urandom(), 2'($urandom));
                else if (r < 62)
                begin
                    pf  = fault_lines(fault_pct);
                    of  = fault_lines(fault_pct);
                    act = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b111;
                    send_word(KIND_SAMPLE, ~pf, of, act, tick, 2'($urandom));
                end
                else if (r < 90)
                    send_word(KIND_EVALUATE, 3'($urandom), 3'($urandom), 3'($urandom), tick,
                              2'($urandom));
                else if (r < 97)
                    send_word(KIND_RESET, 3'($urandom), 3'($urandom), 3'($urandom), tick,
                              2'($urandom_range(0, 3)));
                else
                    send_word(KIND_UNUSED, 3'($urandom), 3'($urandom), 3'($urandom), tick,
                              2'($urandom));
            end
        end

        // let the last status words out, then a short settle
        wait_drained();
        repeat (WINDOW_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("tb_supply_fault_qualifier_top: clean");
        else
            $display("tb_supply_fault_qualifier_top: errors");
        $finish;
    end

endmodule
